[sv/rsi_pkg.sv]
// Shared widths and sideband types for the ray and sphere intersection unit.
package rsi_pkg;

   // Coordinate format and the fraction bits of the unit direction.
   localparam int COORD_W   = 32;
   localparam int UNIT_FRAC = 30;

   // Pipelined square root: radicand and root widths, one root bit per stage.
   localparam int SQ_RAD_W  = 72;
   localparam int SQ_ROOT_W = SQ_RAD_W / 2;
   localparam int SQ_REM_W  = SQ_ROOT_W + 2;

   // Pipelined divider for the direction normalization, one quotient bit per stage.
   localparam int DIV_N_W = 62;
   localparam int DIV_D_W = 32;
   localparam int DIV_Q_W = 31;
   localparam int DIV_R_W = DIV_D_W + 1;

   // Sideband carried alongside the direction length square root.
   typedef struct packed {
      logic                          want;
      logic                          zero;
      logic [2:0]                    dneg;
      logic [2:0][COORD_W-1:0]       p;
      logic [2:0][COORD_W:0]         a;
      logic [2:0][COORD_W-2:0]       dmn;
      logic [67:0]                   aa;
      logic [61:0]                   rr;
   } seg_a_type;

   // Sideband carried alongside the normalization dividers.
   typedef struct packed {
      logic                          want;
      logic                          zero;
      logic [2:0]                    dneg;
      logic [2:0][COORD_W-1:0]       p;
      logic [2:0][COORD_W:0]         a;
      logic [67:0]                   aa;
      logic [61:0]                   rr;
   } seg_b_type;

   // Sideband carried alongside the discriminant square root.
   typedef struct packed {
      logic                          want;
      logic                          zero;
      logic                          miss;
      logic [2:0][COORD_W-1:0]       p;
      logic [2:0][COORD_W-1:0]       u;
      logic [35:0]                   b;
   } seg_c_type;

endpackage

[sv/rsi_isqrt_pipe.sv]
// Pipelined integer square root, floor of the root, one result bit per stage.
module rsi_isqrt_pipe
   import rsi_pkg::*;
(
   input  logic                 clock,
   input  logic                 en,
   input  logic [SQ_RAD_W-1:0]  radicand,
   output logic [SQ_ROOT_W-1:0] root
);

   logic [SQ_RAD_W-1:0]  rad_ff  [SQ_ROOT_W];
   logic [SQ_REM_W-1:0]  rem_ff  [SQ_ROOT_W];
   logic [SQ_ROOT_W-1:0] root_ff [SQ_ROOT_W];

   for (genvar g = 0; g < SQ_ROOT_W; g++) begin : g_stage
      logic [SQ_RAD_W-1:0]  rad_cur;
      logic [SQ_REM_W-1:0]  rem_cur;
      logic [SQ_ROOT_W-1:0] root_cur;
      logic [SQ_REM_W-1:0]  rem_sh;
      logic [SQ_REM_W-1:0]  trial;
      logic                 ge;

      // The first stage starts from the new radicand, the others from the previous stage.
      if (g == 0) begin : g_first
         assign rad_cur  = radicand;
         assign rem_cur  = '0;
         assign root_cur = '0;
      end else begin : g_next
         assign rad_cur  = rad_ff[g-1];
         assign rem_cur  = rem_ff[g-1];
         assign root_cur = root_ff[g-1];
      end

      // Bring down two radicand bits and try the next root bit.
      always_comb begin
         rem_sh = {rem_cur[SQ_REM_W-3:0], rad_cur[SQ_RAD_W-1 -: 2]};
         trial  = {root_cur, 2'b01};
         ge     = rem_sh >= trial;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[g]  <= {rad_cur[SQ_RAD_W-3:0], 2'b00};
            rem_ff[g]  <= ge ? rem_sh - trial : rem_sh;
            root_ff[g] <= {root_cur[SQ_ROOT_W-2:0], ge};
         end
      end
   end

   assign root = root_ff[SQ_ROOT_W-1];

endmodule

[sv/rsi_div_pipe.sv]
// Pipelined restoring divider for the unit direction, one quotient bit per stage.
module rsi_div_pipe
   import rsi_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic [DIV_N_W-1:0] dividend,
   input  logic [DIV_D_W-1:0] divisor,
   output logic [DIV_Q_W-1:0] quotient
);

   logic [DIV_R_W-1:0] rem_ff [DIV_Q_W];
   logic [DIV_Q_W-1:0] low_ff [DIV_Q_W];
   logic [DIV_Q_W-1:0] quo_ff [DIV_Q_W];
   logic [DIV_D_W-1:0] den_ff [DIV_Q_W];

   for (genvar g = 0; g < DIV_Q_W; g++) begin : g_stage
      logic [DIV_R_W-1:0] rem_cur;
      logic [DIV_Q_W-1:0] low_cur;
      logic [DIV_Q_W-1:0] quo_cur;
      logic [DIV_D_W-1:0] den_cur;
      logic [DIV_R_W-1:0] rem_sh;
      logic               ge;

      // The upper dividend bits are already below the divisor, so they seed the remainder.
      if (g == 0) begin : g_first
         assign rem_cur = {{(DIV_R_W - (DIV_N_W - DIV_Q_W)){1'b0}}, dividend[DIV_N_W-1:DIV_Q_W]};
         assign low_cur = dividend[DIV_Q_W-1:0];
         assign quo_cur = '0;
         assign den_cur = divisor;
      end else begin : g_next
         assign rem_cur = rem_ff[g-1];
         assign low_cur = low_ff[g-1];
         assign quo_cur = quo_ff[g-1];
         assign den_cur = den_ff[g-1];
      end

      // Shift in one dividend bit and subtract the divisor when it fits.
      always_comb begin
         rem_sh = {rem_cur[DIV_R_W-2:0], low_cur[DIV_Q_W-1]};
         ge     = rem_sh >= {1'b0, den_cur};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g] <= ge ? rem_sh - {1'b0, den_cur} : rem_sh;
            low_ff[g] <= {low_cur[DIV_Q_W-2:0], 1'b0};
            quo_ff[g] <= {quo_cur[DIV_Q_W-2:0], ge};
            den_ff[g] <= den_cur;
         end
      end
   end

   assign quotient = quo_ff[DIV_Q_W-1];

endmodule

[sv/ray_sphere_intersect_unit.sv]
// Top level of the ray and sphere intersection unit: a fully pipelined Q16.16 datapath.
//
// The unit takes one ray and sphere test per clock while the skid register is free and
// returns one result transaction for each, in order. The path holds three bit-serial
// pipelines: the square root of the direction length (36 stages), the dividers that
// normalize the direction (31 stages) and the square root of the discriminant (36 stages).
// A hit is reported when b*b >= c; the sign of the distance is not checked, so a sphere
// behind the origin also hits, and a zero direction is a miss.
// Distance and hit point are filled in only for a hit with want_contact set, else zero,
// and are saturated to the Q16.16 range. The whole pipeline holds while the output and
// skid registers are both full, so back pressure loses and repeats nothing.
module ray_sphere_intersect_unit
   import rsi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // ray_origin_x, ray_origin_y, ray_origin_z, ray_dir_x, ray_dir_y, ray_dir_z,
   // center_x, center_y, center_z, sphere_radius (31 bits), one zero pad bit
   input  logic [319:0] req_tdata,
   // want_contact
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit_distance, hit_x, hit_y, hit_z
   output logic [127:0] rsp_tdata,
   // hit
   output logic [0:0]   rsp_tuser
);

   localparam int SEG_A_N = SQ_ROOT_W;
   localparam int SEG_B_N = DIV_Q_W;
   localparam int SEG_C_N = SQ_ROOT_W;

   // Clamp helpers for the distance and the hit point.
   function automatic logic [COORD_W-1:0] sat_t(input logic signed [37:0] v);
      logic signed [37:0] hi;
      logic signed [37:0] lo;
      hi = 38'sd2147483647;
      lo = -38'sd2147483648;
      if (v > hi) sat_t = 32'h7fff_ffff;
      else if (v < lo) sat_t = 32'h8000_0000;
      else sat_t = v[COORD_W-1:0];
   endfunction

   function automatic logic [COORD_W-1:0] sat_h(input logic signed [40:0] v);
      logic signed [40:0] hi;
      logic signed [40:0] lo;
      hi = 41'sd2147483647;
      lo = -41'sd2147483648;
      if (v > hi) sat_h = 32'h7fff_ffff;
      else if (v < lo) sat_h = 32'h8000_0000;
      else sat_h = v[COORD_W-1:0];
   endfunction

   logic en;
   logic skid_valid_ff;

   // The pipeline advances as long as the skid register is free.
   assign en         = !skid_valid_ff;
   assign req_tready = en;

   // Stage 1: offset from the centre and direction magnitudes.
   logic                    s1_valid_ff;
   logic                    s1_want_ff;
   logic [2:0]              s1_dneg_ff;
   logic [2:0][COORD_W-1:0] s1_p_ff;
   logic [2:0][COORD_W:0]   s1_a_ff;
   logic [2:0][COORD_W-1:0] s1_dm_ff;
   logic [COORD_W-2:0]      s1_r_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (en) s1_valid_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            logic [COORD_W-1:0] o;
            logic [COORD_W-1:0] d;
            logic [COORD_W-1:0] c;
            o = req_tdata[i*COORD_W +: COORD_W];
            d = req_tdata[(3 + i)*COORD_W +: COORD_W];
            c = req_tdata[(6 + i)*COORD_W +: COORD_W];
            s1_p_ff[i]    <= o;
            s1_a_ff[i]    <= {o[COORD_W-1], o} - {c[COORD_W-1], c};
            s1_dneg_ff[i] <= d[COORD_W-1];
            s1_dm_ff[i]   <= d[COORD_W-1] ? ~d + 1'b1 : d;
         end
         s1_r_ff    <= req_tdata[9*COORD_W +: COORD_W-1];
         s1_want_ff <= req_tuser[0];
      end
   end

   // Stage 2: largest magnitude and the common normalizing shift.
   logic [COORD_W-1:0] s2_m;
   logic [4:0]         s2_msb;
   logic               s2_valid_ff;
   logic               s2_want_ff;
   logic               s2_zero_ff;
   logic               s2_right_ff;
   logic [4:0]         s2_lsh_ff;
   logic [2:0]              s2_dneg_ff;
   logic [2:0][COORD_W-1:0] s2_p_ff;
   logic [2:0][COORD_W:0]   s2_a_ff;
   logic [2:0][COORD_W-1:0] s2_dm_ff;
   logic [COORD_W-2:0]      s2_r_ff;

   always_comb begin
      s2_m = s1_dm_ff[0];
      if (s1_dm_ff[1] > s2_m) s2_m = s1_dm_ff[1];
      if (s1_dm_ff[2] > s2_m) s2_m = s1_dm_ff[2];
      s2_msb = '0;
      for (int k = 0; k < COORD_W; k++) begin
         if (s2_m[k]) s2_msb = 5'(k);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (en) s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_want_ff  <= s1_want_ff;
         s2_zero_ff  <= s2_m == '0;
         s2_right_ff <= s2_m[COORD_W-1];
         s2_lsh_ff   <= 5'(UNIT_FRAC) - s2_msb;
         s2_dneg_ff  <= s1_dneg_ff;
         s2_p_ff     <= s1_p_ff;
         s2_a_ff     <= s1_a_ff;
         s2_dm_ff    <= s1_dm_ff;
         s2_r_ff     <= s1_r_ff;
      end
   end

   // Stage 3: apply the shift so the largest magnitude lies in [2^30, 2^31).
   logic                    s3_valid_ff;
   logic                    s3_want_ff;
   logic                    s3_zero_ff;
   logic [2:0]              s3_dneg_ff;
   logic [2:0][COORD_W-1:0] s3_p_ff;
   logic [2:0][COORD_W:0]   s3_a_ff;
   logic [2:0][COORD_W-2:0] s3_dmn_ff;
   logic [COORD_W-2:0]      s3_r_ff;

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else if (en) s3_valid_ff <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            logic [COORD_W-1:0] sh;
            sh = s2_right_ff ? s2_dm_ff[i] >> 1 : s2_dm_ff[i] << s2_lsh_ff;
            s3_dmn_ff[i] <= sh[COORD_W-2:0];
         end
         s3_want_ff <= s2_want_ff;
         s3_zero_ff <= s2_zero_ff;
         s3_dneg_ff <= s2_dneg_ff;
         s3_p_ff    <= s2_p_ff;
         s3_a_ff    <= s2_a_ff;
         s3_r_ff    <= s2_r_ff;
      end
   end

   // Stage 4: squares of the direction, the offset and the radius.
   logic                    s4_valid_ff;
   logic                    s4_want_ff;
   logic                    s4_zero_ff;
   logic [2:0]              s4_dneg_ff;
   logic [2:0][COORD_W-1:0] s4_p_ff;
   logic [2:0][COORD_W:0]   s4_a_ff;
   logic [2:0][COORD_W-2:0] s4_dmn_ff;
   logic [2:0][61:0]        s4_sq_ff;
   logic [2:0][65:0]        s4_aa_ff;
   logic [61:0]             s4_rr_ff;

   always_ff @(posedge clock) begin
      if (reset) s4_valid_ff <= 1'b0;
      else if (en) s4_valid_ff <= s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            logic signed [65:0] prod;
            prod = $signed(s3_a_ff[i]) * $signed(s3_a_ff[i]);
            s4_sq_ff[i] <= s3_dmn_ff[i] * s3_dmn_ff[i];
            s4_aa_ff[i] <= prod;
         end
         s4_rr_ff   <= s3_r_ff * s3_r_ff;
         s4_want_ff <= s3_want_ff;
         s4_zero_ff <= s3_zero_ff;
         s4_dneg_ff <= s3_dneg_ff;
         s4_p_ff    <= s3_p_ff;
         s4_a_ff    <= s3_a_ff;
         s4_dmn_ff  <= s3_dmn_ff;
      end
   end

   // Stage 5: sums of squares.
   logic        s5_valid_ff;
   logic [63:0] s5_sumsq_ff;
   seg_a_type   s5_seg_ff;

   always_ff @(posedge clock) begin
      if (reset) s5_valid_ff <= 1'b0;
      else if (en) s5_valid_ff <= s4_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_sumsq_ff    <= 64'(s4_sq_ff[0]) + 64'(s4_sq_ff[1]) + 64'(s4_sq_ff[2]);
         s5_seg_ff.aa   <= 68'(s4_aa_ff[0]) + 68'(s4_aa_ff[1]) + 68'(s4_aa_ff[2]);
         s5_seg_ff.rr   <= s4_rr_ff;
         s5_seg_ff.want <= s4_want_ff;
         s5_seg_ff.zero <= s4_zero_ff;
         s5_seg_ff.dneg <= s4_dneg_ff;
         s5_seg_ff.p    <= s4_p_ff;
         s5_seg_ff.a    <= s4_a_ff;
         s5_seg_ff.dmn  <= s4_dmn_ff;
      end
   end

   // Direction length: square root with its sideband delay line.
   logic [SQ_ROOT_W-1:0] len_root;
   logic [SEG_A_N-1:0]   seg_a_valid_ff;
   seg_a_type            seg_a_ff [SEG_A_N];

   rsi_isqrt_pipe u_len_sqrt (
      .clock    (clock),
      .en       (en),
      .radicand ({{(SQ_RAD_W - 64){1'b0}}, s5_sumsq_ff}),
      .root     (len_root)
   );

   always_ff @(posedge clock) begin
      if (reset) seg_a_valid_ff <= '0;
      else if (en) seg_a_valid_ff <= {seg_a_valid_ff[SEG_A_N-2:0], s5_valid_ff};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         seg_a_ff[0] <= s5_seg_ff;
         for (int k = 1; k < SEG_A_N; k++) seg_a_ff[k] <= seg_a_ff[k-1];
      end
   end

   // Stage 6: rounded dividends for the unit components.
   logic                    s6_valid_ff;
   logic [DIV_D_W-1:0]      s6_len_ff;
   logic [2:0][DIV_N_W-1:0] s6_num_ff;
   seg_b_type               s6_seg_ff;
   seg_a_type               sa_end;

   assign sa_end = seg_a_ff[SEG_A_N-1];

   always_ff @(posedge clock) begin
      if (reset) s6_valid_ff <= 1'b0;
      else if (en) s6_valid_ff <= seg_a_valid_ff[SEG_A_N-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s6_num_ff[i] <= {1'b0, sa_end.dmn[i], {UNIT_FRAC{1'b0}}}
                            + DIV_N_W'(len_root[DIV_D_W-1:1]);
         end
         s6_len_ff      <= len_root[DIV_D_W-1:0];
         s6_seg_ff.want <= sa_end.want;
         s6_seg_ff.zero <= sa_end.zero;
         s6_seg_ff.dneg <= sa_end.dneg;
         s6_seg_ff.p    <= sa_end.p;
         s6_seg_ff.a    <= sa_end.a;
         s6_seg_ff.aa   <= sa_end.aa;
         s6_seg_ff.rr   <= sa_end.rr;
      end
   end

   // Normalization dividers with their sideband delay line.
   logic [2:0][DIV_Q_W-1:0] quo;
   logic [SEG_B_N-1:0]      seg_b_valid_ff;
   seg_b_type               seg_b_ff [SEG_B_N];

   for (genvar i = 0; i < 3; i++) begin : g_div
      rsi_div_pipe u_div (
         .clock    (clock),
         .en       (en),
         .dividend (s6_num_ff[i]),
         .divisor  (s6_len_ff),
         .quotient (quo[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) seg_b_valid_ff <= '0;
      else if (en) seg_b_valid_ff <= {seg_b_valid_ff[SEG_B_N-2:0], s6_valid_ff};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         seg_b_ff[0] <= s6_seg_ff;
         for (int k = 1; k < SEG_B_N; k++) seg_b_ff[k] <= seg_b_ff[k-1];
      end
   end

   // Stage 7: signed unit direction.
   logic                    s7_valid_ff;
   logic [2:0][COORD_W-1:0] s7_u_ff;
   seg_b_type               s7_seg_ff;
   seg_b_type               sb_end;

   assign sb_end = seg_b_ff[SEG_B_N-1];

   always_ff @(posedge clock) begin
      if (reset) s7_valid_ff <= 1'b0;
      else if (en) s7_valid_ff <= seg_b_valid_ff[SEG_B_N-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s7_u_ff[i] <= sb_end.dneg[i] ? COORD_W'(0) - {1'b0, quo[i]} : {1'b0, quo[i]};
         end
         s7_seg_ff <= sb_end;
      end
   end

   // Stage 8: products of the unit direction and the offset.
   logic               s8_valid_ff;
   logic [2:0][64:0]   s8_pr_ff;
   logic [2:0][COORD_W-1:0] s8_u_ff;
   seg_b_type          s8_seg_ff;

   always_ff @(posedge clock) begin
      if (reset) s8_valid_ff <= 1'b0;
      else if (en) s8_valid_ff <= s7_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            logic signed [64:0] prod;
            prod = $signed(s7_u_ff[i]) * $signed(s7_seg_ff.a[i]);
            s8_pr_ff[i] <= prod;
         end
         s8_u_ff   <= s7_u_ff;
         s8_seg_ff <= s7_seg_ff;
      end
   end

   // Stage 9: dot product sum.
   logic                    s9_valid_ff;
   logic signed [66:0]      s9_acc_ff;
   logic [2:0][COORD_W-1:0] s9_u_ff;
   seg_b_type               s9_seg_ff;

   always_ff @(posedge clock) begin
      if (reset) s9_valid_ff <= 1'b0;
      else if (en) s9_valid_ff <= s8_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s9_acc_ff <= $signed(s8_pr_ff[0]) + $signed(s8_pr_ff[1]) + $signed(s8_pr_ff[2]);
         s9_u_ff   <= s8_u_ff;
         s9_seg_ff <= s8_seg_ff;
      end
   end

   // Stage 10: b rounded back to the coordinate fraction.
   logic                    s10_valid_ff;
   logic [35:0]             s10_b_ff;
   logic [2:0][COORD_W-1:0] s10_u_ff;
   seg_b_type               s10_seg_ff;
   logic signed [66:0]      s10_rnd;

   assign s10_rnd = s9_acc_ff + (67'sd1 <<< (UNIT_FRAC - 1));

   always_ff @(posedge clock) begin
      if (reset) s10_valid_ff <= 1'b0;
      else if (en) s10_valid_ff <= s9_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s10_b_ff   <= s10_rnd[UNIT_FRAC+35:UNIT_FRAC];
         s10_u_ff   <= s9_u_ff;
         s10_seg_ff <= s9_seg_ff;
      end
   end

   // Stage 11: b squared.
   logic                    s11_valid_ff;
   logic [71:0]             s11_bb_ff;
   logic [35:0]             s11_b_ff;
   logic [2:0][COORD_W-1:0] s11_u_ff;
   seg_b_type               s11_seg_ff;

   always_ff @(posedge clock) begin
      if (reset) s11_valid_ff <= 1'b0;
      else if (en) s11_valid_ff <= s10_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         logic signed [71:0] prod;
         prod = $signed(s10_b_ff) * $signed(s10_b_ff);
         s11_bb_ff  <= prod;
         s11_b_ff   <= s10_b_ff;
         s11_u_ff   <= s10_u_ff;
         s11_seg_ff <= s10_seg_ff;
      end
   end

   // Stage 12: discriminant b*b - |A|^2 + r*r and the miss decision.
   logic               s12_valid_ff;
   logic [71:0]        s12_disc_ff;
   seg_c_type          s12_seg_ff;
   logic signed [71:0] s12_disc;

   assign s12_disc = $signed(s11_bb_ff) - $signed({4'b0, s11_seg_ff.aa})
                     + $signed({10'b0, s11_seg_ff.rr});

   always_ff @(posedge clock) begin
      if (reset) s12_valid_ff <= 1'b0;
      else if (en) s12_valid_ff <= s11_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s12_disc_ff     <= s12_disc;
         s12_seg_ff.miss <= s12_disc[71];
         s12_seg_ff.want <= s11_seg_ff.want;
         s12_seg_ff.zero <= s11_seg_ff.zero;
         s12_seg_ff.p    <= s11_seg_ff.p;
         s12_seg_ff.u    <= s11_u_ff;
         s12_seg_ff.b    <= s11_b_ff;
      end
   end

   // Discriminant square root with its sideband delay line.
   logic [SQ_ROOT_W-1:0] disc_root;
   logic [SEG_C_N-1:0]   seg_c_valid_ff;
   seg_c_type            seg_c_ff [SEG_C_N];

   rsi_isqrt_pipe u_disc_sqrt (
      .clock    (clock),
      .en       (en),
      .radicand (s12_disc_ff),
      .root     (disc_root)
   );

   always_ff @(posedge clock) begin
      if (reset) seg_c_valid_ff <= '0;
      else if (en) seg_c_valid_ff <= {seg_c_valid_ff[SEG_C_N-2:0], s12_valid_ff};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         seg_c_ff[0] <= s12_seg_ff;
         for (int k = 1; k < SEG_C_N; k++) seg_c_ff[k] <= seg_c_ff[k-1];
      end
   end

   // Stage 13: near distance t = -b - sqrt(disc).
   logic               s13_valid_ff;
   logic signed [37:0] s13_t_ff;
   seg_c_type          s13_seg_ff;
   seg_c_type          sc_end;

   assign sc_end = seg_c_ff[SEG_C_N-1];

   always_ff @(posedge clock) begin
      if (reset) s13_valid_ff <= 1'b0;
      else if (en) s13_valid_ff <= seg_c_valid_ff[SEG_C_N-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s13_t_ff   <= -$signed(sc_end.b) - $signed({2'b0, disc_root});
         s13_seg_ff <= sc_end;
      end
   end

   // Stage 14: offsets along the ray and the clamped distance.
   logic               s14_valid_ff;
   logic [2:0][69:0]   s14_ut_ff;
   logic [COORD_W-1:0] s14_t_ff;
   seg_c_type          s14_seg_ff;

   always_ff @(posedge clock) begin
      if (reset) s14_valid_ff <= 1'b0;
      else if (en) s14_valid_ff <= s13_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            logic signed [69:0] prod;
            prod = $signed(s13_seg_ff.u[i]) * s13_t_ff;
            s14_ut_ff[i] <= prod;
         end
         s14_t_ff   <= sat_t(s13_t_ff);
         s14_seg_ff <= s13_seg_ff;
      end
   end

   // Stage 15: hit point and the final result fields.
   logic         s15_valid_ff;
   logic         s15_hit_ff;
   logic [127:0] s15_data_ff;
   logic         s15_hit;
   logic         s15_fill;

   assign s15_hit  = !s14_seg_ff.zero && !s14_seg_ff.miss;
   assign s15_fill = s15_hit && s14_seg_ff.want;

   always_ff @(posedge clock) begin
      if (reset) s15_valid_ff <= 1'b0;
      else if (en) s15_valid_ff <= s14_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s15_hit_ff <= s15_hit;
         s15_data_ff[COORD_W-1:0] <= s15_fill ? s14_t_ff : '0;
         for (int i = 0; i < 3; i++) begin
            logic [69:0]        rnd;
            logic signed [40:0] h;
            rnd = s14_ut_ff[i] + (70'd1 << (UNIT_FRAC - 1));
            h   = $signed(rnd[69:UNIT_FRAC]) + $signed(s14_seg_ff.p[i]);
            s15_data_ff[(i + 1)*COORD_W +: COORD_W] <= s15_fill ? sat_h(h) : '0;
         end
      end
   end

   // Output register with a skid register behind it.
   logic         out_valid_ff;
   logic         out_hit_ff;
   logic [127:0] out_data_ff;
   logic         skid_hit_ff;
   logic [127:0] skid_data_ff;
   logic         inc_valid;
   logic         out_take;

   assign inc_valid = s15_valid_ff && en;
   assign out_take  = out_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (out_take) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (!out_valid_ff || out_take) begin
            out_valid_ff <= inc_valid;
         end else if (inc_valid) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_hit_ff  <= skid_hit_ff;
            out_data_ff <= skid_data_ff;
         end
      end else if (!out_valid_ff || out_take) begin
         out_hit_ff  <= s15_hit_ff;
         out_data_ff <= s15_data_ff;
      end else begin
         skid_hit_ff  <= s15_hit_ff;
         skid_data_ff <= s15_data_ff;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_data_ff;
   assign rsp_tuser[0] = out_hit_ff;

endmodule

[tb/sv/ray_sphere_intersect_unit_tb.sv]
// Testbench for the ray and sphere intersection unit: directed and random ray tests.
`timescale 1ns / 100ps

// Expected result of one ray test.
typedef struct {
   logic        hit;
   logic [31:0] distance;
   logic [31:0] px;
   logic [31:0] py;
   logic [31:0] pz;
} ray_result_type;

// Holds expected results in order and compares each returned transaction with them.
class intersect_scoreboard;
   ray_result_type pending[$];
   int             errors = 0;

   // Exact integer square root of an unsigned 128-bit value, floored.
   static function automatic logic [63:0] isqrt128(logic [127:0] n);
      logic [63:0]  r;
      logic [63:0]  cand;
      r = '0;
      for (int k = 63; k >= 0; k--) begin
         cand = r | (64'd1 << k);
         if ({64'd0, cand} * {64'd0, cand} <= n) r = cand;
      end
      return r;
   endfunction

   // floor((x + 2^29) / 2^30) on a signed 128-bit value.
   static function automatic logic signed [127:0] round30(logic signed [127:0] x);
      return (x + (128'sd1 <<< 29)) >>> 30;
   endfunction

   static function automatic logic [31:0] clamp32(logic signed [127:0] v);
      if (v > 128'sd2147483647) return 32'h7fffffff;
      if (v < -128'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   // Computes the result of one ray test.
   static function automatic ray_result_type compute_intersection(
         logic [319:0] data, logic want);
      ray_result_type          res;
      logic signed [127:0]     p[3], a[3], u[3], d, b, t, acc, aa, disc, h;
      logic [63:0]             dm[3];
      logic [63:0]             m, len, sumsq, q;
      logic                    dneg[3];
      logic [127:0]            r;
      res = '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0};
      m = 0;
      r = {97'd0, data[318:288]};
      for (int i = 0; i < 3; i++) begin
         p[i]    = $signed(data[32*i +: 32]);
         d       = $signed(data[32*(3+i) +: 32]);
         a[i]    = p[i] - $signed(data[32*(6+i) +: 32]);
         dneg[i] = d < 0;
         dm[i]   = dneg[i] ? 64'(-d) : 64'(d);
         if (dm[i] > m) m = dm[i];
      end
      // A zero direction never hits.
      if (m == 0) return res;
      while (m >= (64'd1 << 31)) begin
         for (int i = 0; i < 3; i++) dm[i] = dm[i] >> 1;
         m = m >> 1;
      end
      while (m < (64'd1 << 30)) begin
         for (int i = 0; i < 3; i++) dm[i] = dm[i] << 1;
         m = m << 1;
      end
      sumsq = dm[0]*dm[0] + dm[1]*dm[1] + dm[2]*dm[2];
      len = isqrt128({64'd0, sumsq});
      acc = 0;
      aa  = 0;
      for (int i = 0; i < 3; i++) begin
         q    = ((dm[i] << 30) + (len >> 1)) / len;
         u[i] = dneg[i] ? -$signed({64'd0, q}) : $signed({64'd0, q});
         acc  = acc + u[i] * a[i];
         aa   = aa + a[i] * a[i];
      end
      b    = round30(acc);
      disc = b * b - aa + $signed(r * r);
      if (disc < 0) return res;
      res.hit = 1'b1;
      if (!want) return res;
      t = -b - $signed({64'd0, isqrt128(disc)});
      res.distance = clamp32(t);
      h = p[0] + round30(u[0] * t);
      res.px = clamp32(h);
      h = p[1] + round30(u[1] * t);
      res.py = clamp32(h);
      h = p[2] + round30(u[2] * t);
      res.pz = clamp32(h);
      return res;
   endfunction

   function void note_request(logic [319:0] data, logic want);
      pending.insert(pending.size(), compute_intersection(data, want));
   endfunction

   function void check_response(logic [127:0] data, logic hit);
      ray_result_type exp_res;
      if (pending.size() == 0) begin
         $error("result transaction with no expected result");
         errors++;
         return;
      end
      exp_res = pending.pop_front();
      if (hit !== exp_res.hit) begin
         $error("hit: expected %0b actual %0b", exp_res.hit, hit);
         errors++;
      end
      if (data[31:0] !== exp_res.distance) begin
         $error("hit_distance: expected %h actual %h", exp_res.distance, data[31:0]);
         errors++;
      end
      if (data[63:32] !== exp_res.px) begin
         $error("hit_x: expected %h actual %h", exp_res.px, data[63:32]);
         errors++;
      end
      if (data[95:64] !== exp_res.py) begin
         $error("hit_y: expected %h actual %h", exp_res.py, data[95:64]);
         errors++;
      end
      if (data[127:96] !== exp_res.pz) begin
         $error("hit_z: expected %h actual %h", exp_res.pz, data[127:96]);
         errors++;
      end
   endfunction
endclass

module ray_sphere_intersect_unit_tb;
   localparam int RANDOM_ITEMS = 1500;
   localparam int WATCHDOG     = 20000;
   localparam int DRAIN_CYCLES = 300;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [319:0] req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic [0:0]   rsp_tuser;

   intersect_scoreboard ray_board = new();
   logic sending_done = 1'b0;
   logic hold_off_done = 1'b0;
   int   idle_cycles = 0;

   ray_sphere_intersect_unit u_top (.*);

   always #1 clock = ~clock;

   // Gap length: mostly short, sometimes long.
   function automatic int gap_length();
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // A coordinate: extremes, small values or full-range random.
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return 32'h80000000;
         1: return 32'h7fffffff;
         2: return 32'h0;
         3, 4, 5: return $urandom_range(0, 32'h0001ffff) - 32'h00010000;
         6, 7: return $urandom_range(0, 32'h03ffffff) - 32'h02000000;
         default: return $urandom();
      endcase
   endfunction

   // Offer one transaction and hold it until it is taken.
   task automatic send_ray(logic [31:0] c[9], logic [30:0] rad, logic want);
      for (int i = 0; i < 9; i++) req_tdata[32*i +: 32] <= c[i];
      req_tdata[318:288] <= rad;
      req_tdata[319] <= 1'b0;
      req_tuser <= want;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      ray_board.note_request(req_tdata, req_tuser[0]);
      @(negedge clock);
   endtask

   task automatic send_gap();
      int n;
      n = gap_length();
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // Random ray test; most aim near the sphere so that hits are common.
   task automatic send_random_ray();
      logic [31:0] c[9];
      logic [30:0] rad;
      int          mode;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) c[i] = pick_coord();
      rad = 31'($urandom());
      if (mode < 6) begin
         // Ray from the origin region pointing at the centre, moderate radius.
         for (int i = 0; i < 3; i++) begin
            c[i]   = $urandom_range(0, 32'h00ffffff) - 32'h00800000;
            c[6+i] = $urandom_range(0, 32'h00ffffff) - 32'h00800000;
            c[3+i] = c[6+i] - c[i] + ($urandom_range(0, 32'h000fffff) - 32'h00080000);
         end
         rad = 31'($urandom_range(0, 32'h00400000));
      end else if (mode < 8) begin
         rad = 31'($urandom_range(0, 32'h000fffff));
      end
      send_ray(c, rad, $urandom_range(0, 3) != 0);
      send_gap();
   endtask

   // Sender: directed cases, then random ones.
   initial begin
      logic [31:0] c[9];
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Extremes of every field, zero direction, sphere behind the origin.
      c = '{default: 32'h0};
      send_ray(c, 31'h00010000, 1'b1);
      c[3] = 32'h00010000;
      send_ray(c, 31'h00010000, 1'b1);
      send_ray(c, 31'h00010000, 1'b0);
      c[6] = 32'h00050000;
      send_ray(c, 31'h00010000, 1'b1);
      c[6] = 32'hfffb0000;
      send_ray(c, 31'h00010000, 1'b1);
      c[6] = 32'h00050000; c[7] = 32'h00050000;
      send_ray(c, 31'h00010000, 1'b1);
      c = '{default: 32'h80000000};
      send_ray(c, 31'h7fffffff, 1'b1);
      c = '{default: 32'h7fffffff};
      send_ray(c, 31'h7fffffff, 1'b1);
      c = '{32'h80000000, 32'h7fffffff, 32'h0, 32'h7fffffff, 32'h80000000, 32'h1,
            32'h7fffffff, 32'h80000000, 32'hffffffff};
      send_ray(c, 31'h7fffffff, 1'b1);
      send_ray(c, 31'h0, 1'b0);
      c = '{32'h0, 32'h0, 32'h0, 32'h1, 32'h1, 32'h1, 32'h7fffffff, 32'h7fffffff,
            32'h7fffffff};
      send_ray(c, 31'h7fffffff, 1'b1);
      c = '{32'h0, 32'h0, 32'h0, 32'hffffffff, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
      send_ray(c, 31'h00008000, 1'b1);
      c = '{32'h7fffffff, 32'h0, 32'h0, 32'h00010000, 32'h0, 32'h0, 32'h80000000,
            32'h0, 32'h0};
      send_ray(c, 31'h7fffffff, 1'b1);
      // Back to back items while the receiver holds off, then random rays with gaps.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i < 300) begin
            logic [31:0] cc[9];
            for (int j = 0; j < 9; j++) cc[j] = pick_coord();
            send_ray(cc, 31'($urandom()), 1'($urandom_range(0, 1)));
         end else begin
            send_random_ray();
         end
      end
      req_tvalid <= 1'b0;
      sending_done <= 1'b1;
   end

   // Receiver: a long hold-off early on, then random stalls.
   initial begin
      int n;
      @(negedge clock);
      wait (!reset);
      repeat (400) @(negedge clock);
      hold_off_done <= 1'b1;
      forever begin
         rsp_tready <= 1'b1;
         @(negedge clock);
         n = gap_length();
         if (n > 0 && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(negedge clock);
         end
      end
   end

   // Result check and watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) ray_board.check_response(rsp_tdata, rsp_tuser[0]);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // End of run.
   initial begin
      while (!(sending_done && hold_off_done && ray_board.pending.size() == 0))
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ray_board.errors == 0 && ray_board.pending.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG);
      $display("TB_ERROR");
      $finish;
   end
endmodule

[files.f]
sv/rsi_pkg.sv
sv/rsi_isqrt_pipe.sv
sv/rsi_div_pipe.sv
sv/ray_sphere_intersect_unit.sv
tb/sv/ray_sphere_intersect_unit_tb.sv
